FILE: hdl/cnjs_pkg.sv
// ----------------------------------------------------------------------------
// cnjs_pkg
// Shared types, constants and arithmetic helpers of the Crank-Nicolson
// Jacobi stencil block.
// ----------------------------------------------------------------------------
package cnjs_pkg;

	localparam int GRID_SIDE   = 16;
	localparam int CELLS       = GRID_SIDE * GRID_SIDE;
	localparam int CELL_W      = $clog2(CELLS);
	localparam int SIDE_W      = $clog2(GRID_SIDE);
	localparam int BUFS        = 3;
	localparam int BUF_W       = 2;
	localparam int VEC_DEPTH   = BUFS * CELLS;
	localparam int VEC_ADDR_W  = $clog2(VEC_DEPTH);
	localparam int MUL_W       = 34;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int ACC_W       = PROD_W - 28;
	localparam int NORM_W      = 48;
	localparam int BOUND_W     = 50;
	localparam int DIV_NUM_W   = 60;
	localparam int DIV_DEN_W   = 35;
	localparam int DIV_CNT_W   = $clog2(DIV_NUM_W + 1);
	localparam int SUB_W       = 4;
	localparam int RHS_LAST    = 7;
	localparam int SWEEP_LAST  = 11;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_STEP  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [1:0] STATUS_READ      = 2'd0;
	localparam logic [1:0] STATUS_CONVERGED = 2'd1;
	localparam logic [1:0] STATUS_LIMIT     = 2'd2;

	localparam logic [1:0] CFG_R_IM     = 2'd0;
	localparam logic [1:0] CFG_HALF_DT  = 2'd1;
	localparam logic [1:0] CFG_EPS_SQ   = 2'd2;
	localparam logic [1:0] CFG_MAX_ITER = 2'd3;

	localparam logic [15:0] MAX_ITER_RESET = 16'd1000;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [7:0]          cell_index;
		logic signed [31:0]  wave_re;
		logic signed [31:0]  wave_im;
		logic signed [31:0]  potential;
	} cnjs_req_t;

	typedef struct packed {
		logic signed [31:0]  out_re;
		logic signed [31:0]  out_im;
		logic [1:0]          status;
		logic [15:0]         iterations;
	} cnjs_rsp_t;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} cplx_t;

	typedef struct packed {
		logic signed [31:0] shift;
		cplx_t              recip;
		cplx_t              rhs;
	} coef_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WMUL,
		ST_WSHIFT,
		ST_WSQ,
		ST_WDEN,
		ST_WDIV_RE_GO,
		ST_WDIV_RE,
		ST_WDIV_IM_GO,
		ST_WDIV_IM,
		ST_READ,
		ST_READ_OUT,
		ST_RHS,
		ST_SWEEP,
		ST_FIN_MUL,
		ST_FIN_TEST
	} cnjs_state_t;

	function automatic logic signed [MUL_W-1:0] mext_s(input logic signed [31:0] x);
		return {{(MUL_W-32){x[31]}}, x};
	endfunction

	function automatic logic signed [MUL_W-1:0] mext_u(input logic [31:0] x);
		return {{(MUL_W-32){1'b0}}, x};
	endfunction

	function automatic logic [VEC_ADDR_W-1:0] vaddr(input logic [BUF_W-1:0] b,
			input logic [CELL_W-1:0] k);
		return VEC_ADDR_W'(b) * VEC_ADDR_W'(CELLS) + VEC_ADDR_W'(k);
	endfunction

	// round to nearest, ties up, then drop 28 fraction bits
	function automatic logic signed [ACC_W-1:0] qround(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + (PROD_W'(1) <<< 27);
		return t[PROD_W-1:28];
	endfunction

	function automatic logic [ACC_W-1:0] qfloor(input logic signed [PROD_W-1:0] p);
		return p[PROD_W-1:28];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [BOUND_W-1:0] x);
		logic signed [BOUND_W-1:0] hi;
		logic signed [BOUND_W-1:0] lo;
		hi = {{(BOUND_W-31){1'b0}}, {31{1'b1}}};
		lo = {{(BOUND_W-31){1'b1}}, 31'd0};
		if (x > hi) begin
			return hi[31:0];
		end else if (x < lo) begin
			return lo[31:0];
		end
		return x[31:0];
	endfunction

endpackage

FILE: hdl/cnjs_div.sv
// ----------------------------------------------------------------------------
// cnjs_div
// Restoring divider, one quotient bit per cycle, for the diagonal
// reciprocal of a cell.
// ----------------------------------------------------------------------------
module cnjs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [cnjs_pkg::DIV_NUM_W-1:0]  num,
	input  logic [cnjs_pkg::DIV_DEN_W-1:0]  den,
	output logic                            done,
	output logic [31:0]                     quot
);

	logic [cnjs_pkg::DIV_NUM_W-1:0]  quo_q;
	logic [cnjs_pkg::DIV_DEN_W-1:0]  rem_q;
	logic [cnjs_pkg::DIV_DEN_W-1:0]  den_q;
	logic [cnjs_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                            run_q;
	logic                            done_q;
	logic [cnjs_pkg::DIV_DEN_W:0]    trial;
	logic [cnjs_pkg::DIV_DEN_W:0]    diff;
	logic                            fits;

	assign trial = {rem_q, quo_q[cnjs_pkg::DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= cnjs_pkg::DIV_CNT_W'(cnjs_pkg::DIV_NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - cnjs_pkg::DIV_CNT_W'(1);
				if (cnt_q == cnjs_pkg::DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= fits ? diff[cnjs_pkg::DIV_DEN_W-1:0] : trial[cnjs_pkg::DIV_DEN_W-1:0];
			quo_q <= {quo_q[cnjs_pkg::DIV_NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q[31:0];

endmodule

FILE: hdl/crank_nicolson_jacobi_stencil_top.sv
// ----------------------------------------------------------------------------
// crank_nicolson_jacobi_stencil_top
// One Crank-Nicolson step of the 2D Schrodinger equation on a 16 by 16
// complex grid, solved by Jacobi sweeps over a 5-point stencil.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the request is finished. A read returns one result; a write runs
// two divisions for the diagonal reciprocal and returns none. A step
// builds the right-hand side of every cell, then runs iterations + 1
// Jacobi sweeps; the work per cell is set by the single read port of the
// vector memory (centre and four neighbours read one per cycle) and the
// shared pair of multipliers. The result strobe done is high for exactly
// one cycle and cannot be held off, so the receiver must take it then.
// Cells that were never written read back undefined.
module crank_nicolson_jacobi_stencil_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cnjs_pkg::cnjs_req_t   req,
	output logic                  done,
	output cnjs_pkg::cnjs_rsp_t   result,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	cnjs_pkg::cnjs_state_t state_q, state_d;

	cnjs_pkg::cnjs_req_t  req_q;
	cnjs_pkg::cnjs_rsp_t  result_q;
	logic                 done_q;
	logic                 accept;

	logic [30:0]  r_im_q;
	logic [30:0]  half_dt_q;
	logic [31:0]  eps_sq_q;
	logic [15:0]  max_iter_q;

	logic [cnjs_pkg::BUF_W-1:0]   g_q, src_q, dst_q;
	logic [cnjs_pkg::CELL_W-1:0]  k_q;
	logic [cnjs_pkg::SIDE_W-1:0]  i_q, j_q;
	logic [cnjs_pkg::SUB_W-1:0]   c_q;
	logic [15:0]                  it_q;

	cnjs_pkg::cplx_t  cen_q;
	cnjs_pkg::coef_t  coef_q;
	logic signed [cnjs_pkg::ACC_W-1:0]  acc_re_q, acc_im_q;
	logic signed [31:0]  sr_q, si_q, new_re_q, new_im_q;
	logic [cnjs_pkg::NORM_W-1:0]  uu_q, du_q;
	logic signed [cnjs_pkg::PROD_W-1:0]  mul_a_s1, mul_b_s1;
	logic signed [31:0]  s_q;
	logic [cnjs_pkg::DIV_DEN_W-1:0]  d_q;
	logic signed [31:0]  recip_re_q;

	cnjs_pkg::cplx_t  vec_mem [cnjs_pkg::VEC_DEPTH];
	cnjs_pkg::cplx_t  vec_rd_q;
	cnjs_pkg::coef_t  coef_mem [cnjs_pkg::CELLS];
	cnjs_pkg::coef_t  coef_rd_q;

	logic [cnjs_pkg::VEC_ADDR_W-1:0]  vec_raddr, vec_waddr;
	logic                             vec_we;
	cnjs_pkg::cplx_t                  vec_wdata;
	logic                             coef_we;
	cnjs_pkg::coef_t                  coef_wdata;
	logic [cnjs_pkg::CELL_W-1:0]      coef_waddr;
	logic signed [cnjs_pkg::MUL_W-1:0]  ma_x, ma_y, mb_x, mb_y;
	logic                             div_start;
	logic [cnjs_pkg::DIV_NUM_W-1:0]   div_num;
	logic                             div_done;
	logic [31:0]                      div_quot;

	cnjs_pkg::cplx_t  nb;
	logic             nb_ok;
	logic signed [31:0]  sat_re, sat_im;
	logic signed [cnjs_pkg::ACC_W-1:0]  q_a, q_b;
	logic [cnjs_pkg::ACC_W-1:0]  f_a, f_b;
	logic [cnjs_pkg::BOUND_W-1:0]  bound;
	logic             conv, limit;
	logic [31:0]      abs_s;
	logic signed [31:0]  recip_im;
	logic             in_range;
	logic [cnjs_pkg::CELL_W-1:0]  req_cell;
	logic [cnjs_pkg::BUF_W-1:0]   next_buf;
	logic             cell_end, last_cell;
	logic signed [cnjs_pkg::PROD_W-1:0]  rs16, rs28;
	logic signed [cnjs_pkg::BOUND_W-1:0] s_sum;

	assign accept   = start && !busy;
	assign busy     = state_q != cnjs_pkg::ST_IDLE;
	assign req_cell = cnjs_pkg::CELL_W'(req_q.cell_index);
	assign in_range = int'(req_q.cell_index) < cnjs_pkg::CELLS;
	assign next_buf = (g_q == cnjs_pkg::BUF_W'(cnjs_pkg::BUFS - 1)) ? '0
			: g_q + cnjs_pkg::BUF_W'(1);
	assign last_cell = k_q == cnjs_pkg::CELL_W'(cnjs_pkg::CELLS - 1);
	assign cell_end = ((state_q == cnjs_pkg::ST_RHS)
			&& (c_q == cnjs_pkg::SUB_W'(cnjs_pkg::RHS_LAST)))
			|| ((state_q == cnjs_pkg::ST_SWEEP)
			&& (c_q == cnjs_pkg::SUB_W'(cnjs_pkg::SWEEP_LAST)));

	assign q_a    = cnjs_pkg::qround(mul_a_s1);
	assign q_b    = cnjs_pkg::qround(mul_b_s1);
	assign f_a    = cnjs_pkg::qfloor(mul_a_s1);
	assign f_b    = cnjs_pkg::qfloor(mul_b_s1);
	assign sat_re = cnjs_pkg::sat32(cnjs_pkg::BOUND_W'(acc_re_q));
	assign sat_im = cnjs_pkg::sat32(cnjs_pkg::BOUND_W'(acc_im_q));
	assign bound  = mul_b_s1[cnjs_pkg::BOUND_W-1:0] + cnjs_pkg::BOUND_W'(mul_a_s1[63:32]);
	assign conv   = cnjs_pkg::BOUND_W'(du_q) <= bound;
	assign limit  = it_q == max_iter_q;
	assign abs_s  = s_q[31] ? (~s_q + 32'd1) : s_q;
	assign recip_im = (!s_q[31] && (s_q != '0)) ? -div_quot : div_quot;
	assign rs16   = mul_a_s1 + (cnjs_pkg::PROD_W'(1) <<< 15);
	assign rs28   = mul_a_s1 + (cnjs_pkg::PROD_W'(1) <<< 27);
	assign s_sum  = $signed({{(cnjs_pkg::BOUND_W-33){1'b0}}, r_im_q, 2'b00})
			+ $signed(rs16[cnjs_pkg::BOUND_W+15:16]);

	// neighbour data arrives in the cycle after its read: left, right, up, down
	always_comb begin
		case (c_q)
			cnjs_pkg::SUB_W'(2): nb_ok = i_q != '0;
			cnjs_pkg::SUB_W'(3): nb_ok = i_q != cnjs_pkg::SIDE_W'(cnjs_pkg::GRID_SIDE - 1);
			cnjs_pkg::SUB_W'(4): nb_ok = j_q != '0;
			cnjs_pkg::SUB_W'(5): nb_ok = j_q != cnjs_pkg::SIDE_W'(cnjs_pkg::GRID_SIDE - 1);
			default:             nb_ok = 1'b0;
		endcase
		nb = nb_ok ? vec_rd_q : '0;
	end

	cnjs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (d_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cnjs_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						cnjs_pkg::REQ_WRITE: begin
							if (int'(req.cell_index) < cnjs_pkg::CELLS) begin
								state_d = cnjs_pkg::ST_WMUL;
							end
						end
						cnjs_pkg::REQ_STEP: state_d = cnjs_pkg::ST_RHS;
						cnjs_pkg::REQ_READ: state_d = cnjs_pkg::ST_READ;
						default:            state_d = cnjs_pkg::ST_IDLE;
					endcase
				end
			end
			cnjs_pkg::ST_WMUL:       state_d = cnjs_pkg::ST_WSHIFT;
			cnjs_pkg::ST_WSHIFT:     state_d = cnjs_pkg::ST_WSQ;
			cnjs_pkg::ST_WSQ:        state_d = cnjs_pkg::ST_WDEN;
			cnjs_pkg::ST_WDEN:       state_d = cnjs_pkg::ST_WDIV_RE_GO;
			cnjs_pkg::ST_WDIV_RE_GO: state_d = cnjs_pkg::ST_WDIV_RE;
			cnjs_pkg::ST_WDIV_RE: begin
				if (div_done) begin
					state_d = cnjs_pkg::ST_WDIV_IM_GO;
				end
			end
			cnjs_pkg::ST_WDIV_IM_GO: state_d = cnjs_pkg::ST_WDIV_IM;
			cnjs_pkg::ST_WDIV_IM: begin
				if (div_done) begin
					state_d = cnjs_pkg::ST_IDLE;
				end
			end
			cnjs_pkg::ST_READ:     state_d = cnjs_pkg::ST_READ_OUT;
			cnjs_pkg::ST_READ_OUT: state_d = cnjs_pkg::ST_IDLE;
			cnjs_pkg::ST_RHS: begin
				if (cell_end && last_cell) begin
					state_d = cnjs_pkg::ST_SWEEP;
				end
			end
			cnjs_pkg::ST_SWEEP: begin
				if (cell_end && last_cell) begin
					state_d = cnjs_pkg::ST_FIN_MUL;
				end
			end
			cnjs_pkg::ST_FIN_MUL: state_d = cnjs_pkg::ST_FIN_TEST;
			cnjs_pkg::ST_FIN_TEST: begin
				state_d = (conv || limit) ? cnjs_pkg::ST_IDLE : cnjs_pkg::ST_SWEEP;
			end
			default: state_d = cnjs_pkg::ST_IDLE;
		endcase
	end

	// memory ports, multiplier operands and divider control
	always_comb begin
		vec_raddr  = cnjs_pkg::vaddr(src_q, k_q);
		vec_waddr  = cnjs_pkg::vaddr(dst_q, k_q);
		vec_we     = 1'b0;
		vec_wdata  = '{re: new_re_q, im: new_im_q};
		coef_we    = 1'b0;
		coef_waddr = k_q;
		coef_wdata = coef_q;
		ma_x       = '0;
		ma_y       = '0;
		mb_x       = '0;
		mb_y       = '0;
		div_start  = 1'b0;
		div_num    = (cnjs_pkg::DIV_NUM_W'(1) << 56) + cnjs_pkg::DIV_NUM_W'(d_q >> 1);
		case (state_q)
			cnjs_pkg::ST_WMUL: begin
				ma_x = cnjs_pkg::mext_u({1'b0, half_dt_q});
				ma_y = cnjs_pkg::mext_s(req_q.potential);
			end
			cnjs_pkg::ST_WSQ: begin
				ma_x = cnjs_pkg::mext_s(s_q);
				ma_y = cnjs_pkg::mext_s(s_q);
			end
			cnjs_pkg::ST_WDIV_RE_GO: begin
				div_start = 1'b1;
			end
			cnjs_pkg::ST_WDIV_IM_GO: begin
				div_start = 1'b1;
				div_num = (cnjs_pkg::DIV_NUM_W'(abs_s) << 28)
						+ cnjs_pkg::DIV_NUM_W'(d_q >> 1);
			end
			cnjs_pkg::ST_WDIV_IM: begin
				vec_waddr  = cnjs_pkg::vaddr(g_q, req_cell);
				vec_wdata  = '{re: req_q.wave_re, im: req_q.wave_im};
				vec_we     = div_done;
				coef_waddr = req_cell;
				coef_wdata = '{shift: s_q, recip: '{re: recip_re_q, im: recip_im}, rhs: '0};
				coef_we    = div_done;
			end
			cnjs_pkg::ST_READ: begin
				vec_raddr = cnjs_pkg::vaddr(g_q, req_cell);
			end
			cnjs_pkg::ST_RHS, cnjs_pkg::ST_SWEEP: begin
				case (c_q)
					cnjs_pkg::SUB_W'(1): vec_raddr = cnjs_pkg::vaddr(src_q,
							k_q - cnjs_pkg::CELL_W'(1));
					cnjs_pkg::SUB_W'(2): vec_raddr = cnjs_pkg::vaddr(src_q,
							k_q + cnjs_pkg::CELL_W'(1));
					cnjs_pkg::SUB_W'(3): vec_raddr = cnjs_pkg::vaddr(src_q,
							k_q - cnjs_pkg::CELL_W'(cnjs_pkg::GRID_SIDE));
					cnjs_pkg::SUB_W'(4): vec_raddr = cnjs_pkg::vaddr(src_q,
							k_q + cnjs_pkg::CELL_W'(cnjs_pkg::GRID_SIDE));
					default:             vec_raddr = cnjs_pkg::vaddr(src_q, k_q);
				endcase
				if (c_q == cnjs_pkg::SUB_W'(1)) begin
					if (state_q == cnjs_pkg::ST_RHS) begin
						ma_x = cnjs_pkg::mext_s(coef_rd_q.shift);
						ma_y = cnjs_pkg::mext_s(vec_rd_q.im);
						mb_x = cnjs_pkg::mext_s(coef_rd_q.shift);
						mb_y = cnjs_pkg::mext_s(vec_rd_q.re);
					end else begin
						ma_x = cnjs_pkg::mext_s(vec_rd_q.re);
						ma_y = cnjs_pkg::mext_s(vec_rd_q.re);
						mb_x = cnjs_pkg::mext_s(vec_rd_q.im);
						mb_y = cnjs_pkg::mext_s(vec_rd_q.im);
					end
				end else if (c_q inside {[2:5]}) begin
					ma_x = cnjs_pkg::mext_u({1'b0, r_im_q});
					ma_y = cnjs_pkg::mext_s(nb.im);
					mb_x = cnjs_pkg::mext_u({1'b0, r_im_q});
					mb_y = cnjs_pkg::mext_s(nb.re);
				end else if (c_q == cnjs_pkg::SUB_W'(7)) begin
					if (state_q == cnjs_pkg::ST_RHS) begin
						coef_wdata.rhs = '{re: sat_re, im: sat_im};
						coef_we = 1'b1;
					end else begin
						ma_x = cnjs_pkg::mext_s(sat_re);
						ma_y = cnjs_pkg::mext_s(coef_q.recip.re);
						mb_x = cnjs_pkg::mext_s(sat_im);
						mb_y = cnjs_pkg::mext_s(coef_q.recip.im);
					end
				end else if (c_q == cnjs_pkg::SUB_W'(8)) begin
					ma_x = cnjs_pkg::mext_s(sr_q);
					ma_y = cnjs_pkg::mext_s(coef_q.recip.im);
					mb_x = cnjs_pkg::mext_s(si_q);
					mb_y = cnjs_pkg::mext_s(coef_q.recip.re);
				end else if (c_q == cnjs_pkg::SUB_W'(10)) begin
					vec_we = 1'b1;
					ma_x = cnjs_pkg::mext_s(cen_q.re) - cnjs_pkg::mext_s(new_re_q);
					ma_y = ma_x;
					mb_x = cnjs_pkg::mext_s(cen_q.im) - cnjs_pkg::mext_s(new_im_q);
					mb_y = mb_x;
				end
			end
			cnjs_pkg::ST_FIN_MUL: begin
				ma_x = cnjs_pkg::mext_u(eps_sq_q);
				ma_y = cnjs_pkg::mext_u(uu_q[31:0]);
				mb_x = cnjs_pkg::mext_u(eps_sq_q);
				mb_y = cnjs_pkg::mext_u(32'(uu_q[cnjs_pkg::NORM_W-1:32]));
			end
			default: begin
				vec_we = 1'b0;
			end
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (vec_we) begin
			vec_mem[vec_waddr] <= vec_wdata;
		end
		vec_rd_q <= vec_mem[vec_raddr];
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= coef_wdata;
		end
		coef_rd_q <= coef_mem[k_q];
	end

	// shared multipliers
	always_ff @(posedge clk) begin
		mul_a_s1 <= cnjs_pkg::PROD_W'(ma_x) * cnjs_pkg::PROD_W'(ma_y);
		mul_b_s1 <= cnjs_pkg::PROD_W'(mb_x) * cnjs_pkg::PROD_W'(mb_y);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cnjs_pkg::ST_IDLE;
			r_im_q     <= '0;
			half_dt_q  <= '0;
			eps_sq_q   <= '0;
			max_iter_q <= cnjs_pkg::MAX_ITER_RESET;
			g_q        <= '0;
			src_q      <= '0;
			dst_q      <= '0;
			k_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			c_q        <= '0;
			it_q       <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					cnjs_pkg::CFG_R_IM:     r_im_q     <= cfg_data[30:0];
					cnjs_pkg::CFG_HALF_DT:  half_dt_q  <= cfg_data[30:0];
					cnjs_pkg::CFG_EPS_SQ:   eps_sq_q   <= cfg_data;
					cnjs_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data[15:0];
					default:                eps_sq_q   <= eps_sq_q;
				endcase
			end
			if (accept) begin
				c_q   <= '0;
				k_q   <= '0;
				i_q   <= '0;
				j_q   <= '0;
				it_q  <= '0;
				src_q <= g_q;
				dst_q <= next_buf;
			end
			if ((state_q == cnjs_pkg::ST_RHS) || (state_q == cnjs_pkg::ST_SWEEP)) begin
				if (cell_end) begin
					c_q <= '0;
					if (last_cell) begin
						k_q <= '0;
						i_q <= '0;
						j_q <= '0;
					end else begin
						k_q <= k_q + cnjs_pkg::CELL_W'(1);
						if (i_q == cnjs_pkg::SIDE_W'(cnjs_pkg::GRID_SIDE - 1)) begin
							i_q <= '0;
							j_q <= j_q + cnjs_pkg::SIDE_W'(1);
						end else begin
							i_q <= i_q + cnjs_pkg::SIDE_W'(1);
						end
					end
				end else begin
					c_q <= c_q + cnjs_pkg::SUB_W'(1);
				end
			end
			if (state_q == cnjs_pkg::ST_READ_OUT) begin
				done_q <= 1'b1;
			end
			if (state_q == cnjs_pkg::ST_FIN_TEST) begin
				if (conv || limit) begin
					done_q <= 1'b1;
					if (!limit) begin
						g_q <= dst_q;
					end
				end else begin
					it_q  <= it_q + 16'd1;
					src_q <= dst_q;
					dst_q <= cnjs_pkg::BUF_W'(cnjs_pkg::BUFS) - g_q - dst_q;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		case (state_q)
			cnjs_pkg::ST_WSHIFT: s_q <= cnjs_pkg::sat32(s_sum);
			cnjs_pkg::ST_WDEN: begin
				d_q <= (cnjs_pkg::DIV_DEN_W'(1) << 28)
						+ rs28[cnjs_pkg::DIV_DEN_W+27:28];
			end
			cnjs_pkg::ST_WDIV_RE: begin
				if (div_done) begin
					recip_re_q <= div_quot;
				end
			end
			cnjs_pkg::ST_READ_OUT: begin
				result_q.out_re     <= in_range ? vec_rd_q.re : '0;
				result_q.out_im     <= in_range ? vec_rd_q.im : '0;
				result_q.status     <= cnjs_pkg::STATUS_READ;
				result_q.iterations <= '0;
			end
			cnjs_pkg::ST_FIN_TEST: begin
				result_q.out_re     <= '0;
				result_q.out_im     <= '0;
				result_q.status     <= limit ? cnjs_pkg::STATUS_LIMIT
						: cnjs_pkg::STATUS_CONVERGED;
				result_q.iterations <= it_q;
				uu_q <= '0;
				du_q <= '0;
			end
			cnjs_pkg::ST_RHS, cnjs_pkg::ST_SWEEP: begin
				if (state_q == cnjs_pkg::ST_RHS) begin
					uu_q <= '0;
					du_q <= '0;
				end
				if (c_q == cnjs_pkg::SUB_W'(1)) begin
					cen_q  <= vec_rd_q;
					coef_q <= coef_rd_q;
				end else if (c_q == cnjs_pkg::SUB_W'(2)) begin
					if (state_q == cnjs_pkg::ST_RHS) begin
						acc_re_q <= cnjs_pkg::ACC_W'(cen_q.re) + q_a;
						acc_im_q <= cnjs_pkg::ACC_W'(cen_q.im) - q_b;
					end else begin
						acc_re_q <= cnjs_pkg::ACC_W'(coef_q.rhs.re);
						acc_im_q <= cnjs_pkg::ACC_W'(coef_q.rhs.im);
						uu_q <= uu_q + cnjs_pkg::NORM_W'(f_a) + cnjs_pkg::NORM_W'(f_b);
					end
				end else if (c_q inside {[3:6]}) begin
					acc_re_q <= acc_re_q - q_a;
					acc_im_q <= acc_im_q + q_b;
				end else if (c_q == cnjs_pkg::SUB_W'(7)) begin
					sr_q <= sat_re;
					si_q <= sat_im;
				end else if (c_q == cnjs_pkg::SUB_W'(8)) begin
					new_re_q <= cnjs_pkg::sat32(cnjs_pkg::BOUND_W'(q_a - q_b));
				end else if (c_q == cnjs_pkg::SUB_W'(9)) begin
					new_im_q <= cnjs_pkg::sat32(cnjs_pkg::BOUND_W'(q_a + q_b));
				end else if (c_q == cnjs_pkg::SUB_W'(11)) begin
					du_q <= du_q + cnjs_pkg::NORM_W'(f_a) + cnjs_pkg::NORM_W'(f_b);
				end
			end
			default: begin
				s_q <= s_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	a_grid_buf: assert property (@(posedge clk) disable iff (!arst_n)
		g_q != cnjs_pkg::BUF_W'(cnjs_pkg::BUFS))
		else $error("grid buffer pointer out of range");

	a_sweep_bufs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cnjs_pkg::ST_SWEEP) |-> (src_q != dst_q) && (dst_q != g_q))
		else $error("sweep would overwrite its source or the grid");

	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == cnjs_pkg::STATUS_LIMIT))
			|-> (result.iterations == max_iter_q))
		else $error("limit status with wrong sweep count");

endmodule

FILE: tb/crank_nicolson_jacobi_stencil_chk.sv
// ----------------------------------------------------------------------------
// crank_nicolson_jacobi_stencil_chk
// Watches the request, result and register ports of the Crank-Nicolson
// stencil block. It keeps its own copy of the grid, the diagonal terms and
// the registers, works out the result of every accepted read and step and
// compares each strobed result with the oldest one still owed.
// ----------------------------------------------------------------------------
module crank_nicolson_jacobi_stencil_chk (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  cnjs_pkg::cnjs_req_t   req,
	input  logic                  done,
	input  cnjs_pkg::cnjs_rsp_t   result,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	output int                    errors,
	output int                    pending
);

	longint unsigned reg_rim, reg_hdt, reg_eps, reg_maxit;
	int grid_re[cnjs_pkg::CELLS], grid_im[cnjs_pkg::CELLS], shift_q[cnjs_pkg::CELLS];
	int inv_re[cnjs_pkg::CELLS], inv_im[cnjs_pkg::CELLS];
	int b_re[cnjs_pkg::CELLS], b_im[cnjs_pkg::CELLS];
	int old_re[cnjs_pkg::CELLS], old_im[cnjs_pkg::CELLS];
	int new_re[cnjs_pkg::CELLS], new_im[cnjs_pkg::CELLS];
	cnjs_pkg::cnjs_rsp_t owed_q[$];

	initial begin
		errors = 0;
		for (int k = 0; k < cnjs_pkg::CELLS; k++) begin
			grid_re[k] = 0; grid_im[k] = 0; shift_q[k] = 0;
			inv_re[k] = 0; inv_im[k] = 0;
		end
	end

	assign pending = owed_q.size();

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
	endtask

	function automatic longint rnd_shift(input longint x, input int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic int clip32(input longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return int'(x);
	endfunction

	function automatic longint qmul28(input longint a, input longint b);
		return rnd_shift(a * b, 28);
	endfunction

	function automatic longint unsigned mag_sq(input longint x);
		longint unsigned m;
		m = (x < 0) ? longint'(-x) : x;
		return (m * m) >> 28;
	endfunction

	// r times the in-grid neighbours, from the grid or from the old iterate
	function automatic void stencil_add(input int k, input bit from_old,
			inout longint ar, inout longint ai);
		int i, j, nb;
		int nbs[$];
		i = k % cnjs_pkg::GRID_SIDE;
		j = k / cnjs_pkg::GRID_SIDE;
		if (i > 0) nbs.push_back(k - 1);
		if (i + 1 < cnjs_pkg::GRID_SIDE) nbs.push_back(k + 1);
		if (j > 0) nbs.push_back(k - cnjs_pkg::GRID_SIDE);
		if (j + 1 < cnjs_pkg::GRID_SIDE) nbs.push_back(k + cnjs_pkg::GRID_SIDE);
		foreach (nbs[m]) begin
			nb = nbs[m];
			ar -= qmul28(longint'(reg_rim), from_old ? old_im[nb] : grid_im[nb]);
			ai += qmul28(longint'(reg_rim), from_old ? old_re[nb] : grid_re[nb]);
		end
	endfunction

	function automatic void jacobi_pass();
		longint tr, ti;
		int sr, si;
		for (int k = 0; k < cnjs_pkg::CELLS; k++) begin
			tr = b_re[k];
			ti = b_im[k];
			stencil_add(k, 1'b1, tr, ti);
			sr = clip32(tr);
			si = clip32(ti);
			new_re[k] = clip32(qmul28(sr, inv_re[k]) - qmul28(si, inv_im[k]));
			new_im[k] = clip32(qmul28(sr, inv_im[k]) + qmul28(si, inv_re[k]));
		end
	endfunction

	function automatic bit norm_ok();
		longint unsigned du, uu, bound;
		du = 0;
		uu = 0;
		for (int k = 0; k < cnjs_pkg::CELLS; k++) begin
			uu += mag_sq(old_re[k]) + mag_sq(old_im[k]);
			du += mag_sq(longint'(old_re[k]) - new_re[k]);
			du += mag_sq(longint'(old_im[k]) - new_im[k]);
		end
		bound = reg_eps * (uu >> 32) + ((reg_eps * (uu & 64'hffffffff)) >> 32);
		return du <= bound;
	endfunction

	function automatic void load_cell(input int k, input int wr, input int wi, input int v);
		longint s, as_, d, q;
		s = clip32(4 * longint'(reg_rim) + rnd_shift(longint'(reg_hdt) * v, 16));
		grid_re[k] = wr;
		grid_im[k] = wi;
		shift_q[k] = int'(s);
		as_ = (s < 0) ? -s : s;
		d = (64'sd1 <<< 28) + (((as_ * as_) + (64'sd1 <<< 27)) >>> 28);
		inv_re[k] = int'(((64'sd1 <<< 56) + d / 2) / d);
		q = ((as_ <<< 28) + d / 2) / d;
		inv_im[k] = int'((s > 0) ? -q : q);
	endfunction

	function automatic cnjs_pkg::cnjs_rsp_t time_step();
		cnjs_pkg::cnjs_rsp_t r;
		longint br, bi;
		int it;
		for (int k = 0; k < cnjs_pkg::CELLS; k++) begin
			br = longint'(grid_re[k]) + qmul28(shift_q[k], grid_im[k]);
			bi = longint'(grid_im[k]) - qmul28(shift_q[k], grid_re[k]);
			stencil_add(k, 1'b0, br, bi);
			b_re[k] = clip32(br);
			b_im[k] = clip32(bi);
		end
		old_re = grid_re;
		old_im = grid_im;
		jacobi_pass();
		it = 0;
		while (!norm_ok() && it < reg_maxit) begin
			it++;
			old_re = new_re;
			old_im = new_im;
			jacobi_pass();
		end
		r = '0;
		r.iterations = it[15:0];
		if (it == reg_maxit) begin
			r.status = cnjs_pkg::STATUS_LIMIT;
		end else begin
			r.status = cnjs_pkg::STATUS_CONVERGED;
			grid_re = new_re;
			grid_im = new_im;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cnjs_pkg::cnjs_rsp_t want, r;
		if (!arst_n) begin
			reg_rim = 0;
			reg_hdt = 0;
			reg_eps = 0;
			reg_maxit = cnjs_pkg::MAX_ITER_RESET;
			owed_q.delete();
		end else begin
			if (done) begin
				if (owed_q.size() == 0) begin
					report_mismatch("result with nothing owed", result.status, -1);
				end else begin
					want = owed_q.pop_front();
					if (result.out_re !== want.out_re)
						report_mismatch("out_re", result.out_re, want.out_re);
					if (result.out_im !== want.out_im)
						report_mismatch("out_im", result.out_im, want.out_im);
					if (result.status !== want.status)
						report_mismatch("status", result.status, want.status);
					if (result.iterations !== want.iterations)
						report_mismatch("iterations", result.iterations, want.iterations);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					cnjs_pkg::CFG_R_IM:     reg_rim = cfg_data[30:0];
					cnjs_pkg::CFG_HALF_DT:  reg_hdt = cfg_data[30:0];
					cnjs_pkg::CFG_EPS_SQ:   reg_eps = cfg_data;
					cnjs_pkg::CFG_MAX_ITER: reg_maxit = cfg_data[15:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (req.req_type)
					cnjs_pkg::REQ_WRITE: load_cell(req.cell_index, req.wave_re,
							req.wave_im, req.potential);
					cnjs_pkg::REQ_STEP: owed_q.push_back(time_step());
					cnjs_pkg::REQ_READ: begin
						r = '0;
						r.status = cnjs_pkg::STATUS_READ;
						r.out_re = grid_re[req.cell_index];
						r.out_im = grid_im[req.cell_index];
						owed_q.push_back(r);
					end
					default: ;
				endcase
			end
		end
	end

	task automatic flush_check();
		while (owed_q.size() > 0) begin
			want_left(owed_q.pop_front());
		end
	endtask

	task automatic want_left(input cnjs_pkg::cnjs_rsp_t w);
		report_mismatch("result never came, status", -1, w.status);
	endtask

endmodule

FILE: tb/crank_nicolson_jacobi_stencil_top_tb.sv
// ----------------------------------------------------------------------------
// crank_nicolson_jacobi_stencil_top_tb
// Fills the whole grid, runs a directed set of reads, writes with extreme
// values, an unknown request and a step, then random phases of writes,
// reads, steps and unknown requests under several register settings.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module crank_nicolson_jacobi_stencil_top_tb;

	localparam int IDLE_LIMIT = 400000;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	cnjs_pkg::cnjs_req_t  req = '0;
	logic                 done;
	cnjs_pkg::cnjs_rsp_t  result;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = cnjs_pkg::CFG_R_IM;
	logic [31:0]          cfg_data = '0;
	int                   errors, pending;
	int                   idle_cycles = 0;
	int                   n_write = 0, n_read = 0, n_step = 0, n_odd = 0;

	always #5 clk = ~clk;

	crank_nicolson_jacobi_stencil_top u_top (
		.clk, .arst_n, .start, .busy, .req, .done, .result,
		.cfg_we, .cfg_index, .cfg_data
	);

	crank_nicolson_jacobi_stencil_chk u_chk (
		.clk, .arst_n, .start, .busy, .req, .done, .result,
		.cfg_we, .cfg_index, .cfg_data, .errors, .pending
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("crank_nicolson_jacobi_stencil_top_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value();
		int p;
		p = $urandom_range(0, 99);
		if (p < 4) return 32'h80000000;
		if (p < 8) return 32'h7fffffff;
		if (p < 20) return $urandom;
		return $urandom_range(0, 32'h0fffffff) - 32'h08000000;
	endfunction

	task automatic gap();
		int p, n;
		p = $urandom_range(0, 99);
		n = (p < 55) ? 0 : (p < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic issue(input logic [1:0] kind, input logic [7:0] k,
			input logic [31:0] wr, input logic [31:0] wi, input logic [31:0] v);
		bit taken;
		req.req_type = kind;
		req.cell_index = k;
		req.wave_re = wr;
		req.wave_im = wi;
		req.potential = v;
		start = 1'b1;
		do begin
			taken = !busy;
			@(negedge clk);
		end while (!taken);
		case (kind)
			cnjs_pkg::REQ_WRITE: n_write++;
			cnjs_pkg::REQ_READ:  n_read++;
			cnjs_pkg::REQ_STEP:  n_step++;
			default:             n_odd++;
		endcase
		gap();
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int p;
		logic [31:0] rim, hdt, eps, mit;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int k = 0; k < cnjs_pkg::CELLS; k++)
			issue(cnjs_pkg::REQ_WRITE, 8'(k), pick_value(), pick_value(), pick_value());

		issue(cnjs_pkg::REQ_READ, 8'd0, 0, 0, 0);
		issue(cnjs_pkg::REQ_READ, 8'(cnjs_pkg::CELLS - 1), 0, 0, 0);
		issue(cnjs_pkg::REQ_WRITE, 8'd5, 32'h80000000, 32'h7fffffff, 32'h80000000);
		issue(cnjs_pkg::REQ_WRITE, 8'd6, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		issue(cnjs_pkg::REQ_READ, 8'd5, 0, 0, 0);
		issue(cnjs_pkg::REQ_READ, 8'd6, 0, 0, 0);
		issue(REQ_UNKNOWN, 8'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		issue(cnjs_pkg::REQ_STEP, 8'hff, 0, 0, 0);
		issue(cnjs_pkg::REQ_READ, 8'd17, 0, 0, 0);
		issue(cnjs_pkg::REQ_READ, 8'd5, 0, 0, 0);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			rim = (ph == 1) ? 32'hffffffff : (ph == 2) ? 32'd0 : $urandom_range(0, 1 << 24);
			hdt = (ph == 1) ? 32'hffffffff : (ph == 3) ? 32'd0 : $urandom_range(0, 1 << 22);
			eps = (ph == 2) ? 32'd0 : (ph == 4) ? 32'hffffffff : $urandom;
			mit = (ph == 5) ? 32'hffff0000 | 32'd65535 : (ph == 6) ? 32'd1
					: $urandom_range(1, 6);
			set_reg(cnjs_pkg::CFG_R_IM, rim);
			set_reg(cnjs_pkg::CFG_HALF_DT, hdt);
			set_reg(cnjs_pkg::CFG_EPS_SQ, eps);
			set_reg(cnjs_pkg::CFG_MAX_ITER, mit);
			for (int n = 0; n < 40; n++) begin
				p = $urandom_range(0, 99);
				if (p < 6 && ph != 5) begin
					issue(cnjs_pkg::REQ_STEP, 8'($urandom), $urandom, $urandom, $urandom);
				end else if (p < 10) begin
					issue(REQ_UNKNOWN, 8'($urandom), $urandom, $urandom, $urandom);
					n--;
				end else if (p < 55) begin
					issue(cnjs_pkg::REQ_READ, 8'($urandom), $urandom, $urandom, $urandom);
				end else begin
					issue(cnjs_pkg::REQ_WRITE, 8'($urandom), pick_value(), pick_value(),
							pick_value());
				end
			end
		end

		drain();
		u_chk.flush_check();
		$display("covered %0d writes, %0d reads, %0d steps, %0d unknown requests",
				n_write, n_read, n_step, n_odd);
		$display("over eight register settings including zero and full-scale values");
		if (errors == 0) begin
			$display("crank_nicolson_jacobi_stencil_top_tb: done, clean");
		end else begin
			$display("crank_nicolson_jacobi_stencil_top_tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/cnjs_pkg.sv
hdl/cnjs_div.sv
hdl/crank_nicolson_jacobi_stencil_top.sv
tb/crank_nicolson_jacobi_stencil_chk.sv
tb/crank_nicolson_jacobi_stencil_top_tb.sv
